FILE: hw/rtl/assert_macros.svh
// Assertion helpers, compiled out for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define DSPM_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define DSPM_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) ante |=> cons) else $error(msg);
`else
`define DSPM_ASSERT(lbl, clk, rstn, prop, msg)
`define DSPM_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

FILE: hw/rtl/dspm_pkg.sv
`default_nettype none
package dspm_pkg;

    typedef enum logic [1:0] {
        REQ_CLEAR  = 2'd0,
        REQ_APPEND = 2'd1,
        REQ_TEXT   = 2'd2,
        REQ_EOT    = 2'd3
    } t_req;

    localparam logic [7:0] STAR_CHAR = 8'h2A;
    localparam logic [7:0] DOT_CHAR  = 8'h2E;

    typedef struct packed {
        logic       fire;
        t_req       req;
        logic [7:0] data;
    } t_cmd;

    typedef struct packed {
        logic hit;
        logic overflow;
    } t_res;

endpackage
`default_nettype wire

FILE: hw/rtl/dspm_engine.sv
`default_nettype none
`include "assert_macros.svh"
module dspm_engine #(
    parameter int MAX_TOKENS = 32
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire dspm_pkg::t_cmd i_cmd,
    output dspm_pkg::t_res     o_res
);
    import dspm_pkg::*;

    localparam int NP = MAX_TOKENS + 1;
    localparam int CW = $clog2(MAX_TOKENS + 1);
    localparam int IW = (MAX_TOKENS > 1) ? $clog2(MAX_TOKENS) : 1;

    logic [7:0]            r_tok_byte [MAX_TOKENS];
    logic [MAX_TOKENS-1:0] r_tok_any;
    logic [MAX_TOKENS-1:0] r_tok_star;
    logic [CW-1:0]         r_count;
    logic [NP-1:0]         r_active;
    logic                  r_overflow;

    logic [NP-1:0]         pos_mask;
    logic [MAX_TOKENS-1:0] tok_valid;
    logic [NP-1:0]         clos;
    logic [MAX_TOKENS-1:0] hit;
    logic [NP-1:0]         n_active_text;
    logic [IW-1:0]         last_idx;
    logic [IW-1:0]         wr_idx;
    logic                  full;
    logic                  star_cond;
    logic                  do_append;

    // positions 0..count are live
    always_comb begin
        for (int p = 0; p < NP; p++) begin
            pos_mask[p] = (CW'(p) <= r_count);
        end
    end
    assign tok_valid = pos_mask[NP-1:1];

    // closure over starred tokens, rippling up
    always_comb begin
        clos[0] = r_active[0];
        for (int p = 0; p < MAX_TOKENS; p++) begin
            clos[p+1] = r_active[p+1] | (clos[p] & r_tok_star[p] & tok_valid[p]);
        end
    end

    always_comb begin
        for (int p = 0; p < MAX_TOKENS; p++) begin
            hit[p] = clos[p] & tok_valid[p] &
                     (r_tok_any[p] | (r_tok_byte[p] == i_cmd.data));
        end
    end
    assign n_active_text = {hit & ~r_tok_star, 1'b0} | {1'b0, hit & r_tok_star};

    assign last_idx  = IW'(r_count - 1'b1);
    assign wr_idx    = IW'(r_count);
    assign full      = (r_count == CW'(MAX_TOKENS));
    assign star_cond = (i_cmd.data == STAR_CHAR) && (r_count != '0) && !r_tok_star[last_idx];
    assign do_append = i_cmd.fire && (i_cmd.req == REQ_APPEND) && !r_overflow;

    assign o_res.hit      = clos[r_count] & ~r_overflow;
    assign o_res.overflow = r_overflow;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_active   <= NP'(1);
            r_overflow <= 1'b0;
        end else if (i_cmd.fire) begin
            unique case (i_cmd.req)
                REQ_CLEAR: begin
                    r_count    <= '0;
                    r_overflow <= 1'b0;
                    r_active   <= NP'(1);
                end
                REQ_APPEND: begin
                    r_active <= NP'(1);
                    if (!r_overflow && !star_cond) begin
                        if (full) begin
                            r_overflow <= 1'b1;
                        end else begin
                            r_count <= r_count + 1'b1;
                        end
                    end
                end
                REQ_TEXT: begin
                    r_active <= n_active_text;
                end
                REQ_EOT: begin
                    r_active <= NP'(1);
                end
                default: begin
                    r_active <= NP'(1);
                end
            endcase
        end
    end

    // token store, no reset: only entries below count are read
    always_ff @(posedge i_clk) begin
        if (do_append) begin
            if (star_cond) begin
                r_tok_star[last_idx] <= 1'b1;
            end else if (!full) begin
                r_tok_byte[wr_idx] <= i_cmd.data;
                r_tok_any[wr_idx]  <= (i_cmd.data == DOT_CHAR);
                r_tok_star[wr_idx] <= 1'b0;
            end
        end
    end

    `DSPM_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= CW'(MAX_TOKENS), "token count past limit")
    `DSPM_ASSERT(a_set_in_range, i_clk, i_rst_n, (r_active & ~pos_mask) == '0, "position beyond pattern end")
    `DSPM_ASSERT_NEXT(a_clear, i_clk, i_rst_n, i_cmd.fire && i_cmd.req == REQ_CLEAR, r_count == '0 && !r_overflow, "clear did not empty pattern")

endmodule
`default_nettype wire

FILE: hw/rtl/dot_star_pattern_matcher_top.sv
// Dot-star pattern matcher.
// Input channel (i_in_valid / o_in_stall) carries one word per item: i_req_type
// selects clear pattern, append pattern byte, text byte or end of text, and
// i_byte_value carries the byte. Load a pattern with append words (a '*' after
// an unstarred token stars it), then stream text bytes and close with an end of
// text word. Only end of text gives a result word on the output channel
// (o_out_valid / i_out_stall): o_is_match, and o_pattern_overflow when the
// pattern ran past MAX_TOKENS tokens (o_is_match is then 0).
// Each word is held in the input register and applied to the engine at the edge
// on which it fires; an end-of-text result is loaded into the output register at
// that same edge, so it passes the input register and then the output register.
// The closure and step over the position set are combinational, so one word is
// accepted per cycle, except that while a result waits under stall, a following
// end-of-text word waits for the output register; pattern and text words flow on.
// Synchronous reset empties the pattern, clears overflow and drops both valids.
`default_nettype none
`include "assert_macros.svh"
module dot_star_pattern_matcher_top #(
    parameter int MAX_TOKENS = 32
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire logic [1:0] i_req_type,
    input  wire logic [7:0] i_byte_value,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output logic            o_is_match,
    output logic            o_pattern_overflow
);
    import dspm_pkg::*;

    logic       r_in_valid;
    t_req       r_req;
    logic [7:0] r_byte;
    logic       r_out_valid;
    logic       r_is_match;
    logic       r_pat_ovf;

    logic       out_free;
    logic       fire;
    logic       res_load;
    t_cmd       cmd;
    t_res       res;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign fire       = r_in_valid && ((r_req != REQ_EOT) || out_free);
    assign res_load   = fire && (r_req == REQ_EOT);
    assign o_in_stall = r_in_valid && !fire;

    assign cmd.fire = fire;
    assign cmd.req  = r_req;
    assign cmd.data = r_byte;

    dspm_engine #(
        .MAX_TOKENS(MAX_TOKENS)
    ) u_engine (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd  (cmd),
        .o_res  (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (res_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_req  <= t_req'(i_req_type);
            r_byte <= i_byte_value;
        end
        if (res_load) begin
            r_is_match <= res.hit;
            r_pat_ovf  <= res.overflow;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_is_match         = r_is_match;
    assign o_pattern_overflow = r_pat_ovf;

    `DSPM_ASSERT(a_ovf_no_match, i_clk, i_rst_n, (o_out_valid && o_pattern_overflow) |-> !o_is_match, "match reported with overflow")
    `DSPM_ASSERT(a_result_source, i_clk, i_rst_n, $rose(r_out_valid) |-> $past(res_load), "result word without end of text")
    `DSPM_ASSERT(a_no_block, i_clk, i_rst_n, (r_in_valid && r_req != REQ_EOT) |-> !o_in_stall, "non-result word blocked")

endmodule
`default_nettype wire

FILE: tb/dot_star_pattern_matcher_top_test.sv
`timescale 1ns / 100ps
module dot_star_pattern_matcher_top_test;
    import dspm_pkg::*;

    localparam int MAX_TOKENS  = 32;
    localparam int N_RANDOM    = 1650;
    localparam int N_DIRECTED  = 25;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 300;
    localparam logic [7:0] CH_A = 8'h61;
    localparam logic [7:0] CH_B = 8'h62;
    localparam logic [MAX_TOKENS:0] POS_ZERO = {{MAX_TOKENS{1'b0}}, 1'b1};

    typedef struct packed {
        logic hit;
        logic ovf;
    } t_verdict;

    typedef struct packed {
        t_req       req;
        logic [7:0] bval;
        logic       fixed;
        logic       hit;
        logic       ovf;
    } t_dir_row;

    logic       i_clk     = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    t_req       in_req    = REQ_CLEAR;
    logic [7:0] in_byte   = 8'h00;
    logic       out_stall = 1'b0;
    wire        in_stall;
    wire        out_valid;
    wire        is_match;
    wire        overflow;

    int send_idle_pct = 0;
    int stall_pct     = 0;
    int hold_left     = 0;
    int words_sent    = 0;
    int err_count     = 0;
    int cycles        = 0;

    // matcher state as seen by the checker
    logic [7:0]        pat_byte [MAX_TOKENS];
    logic              pat_any  [MAX_TOKENS];
    logic              pat_star [MAX_TOKENS];
    int                pat_len  = 0;
    logic [MAX_TOKENS:0] reach  = POS_ZERO;
    logic              pat_ovf  = 1'b0;
    t_verdict          verdict_q[$];

    dot_star_pattern_matcher_top #(
        .MAX_TOKENS(MAX_TOKENS)
    ) i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (in_valid),
        .o_in_stall        (in_stall),
        .i_req_type        (in_req),
        .i_byte_value      (in_byte),
        .o_out_valid       (out_valid),
        .i_out_stall       (out_stall),
        .o_is_match        (is_match),
        .o_pattern_overflow(overflow)
    );

    always #10 i_clk = ~i_clk;

    function automatic void report_error(string msg);
        err_count++;
        if (err_count <= 10) begin
            $display("ERROR @%0t: %s", $time, msg);
        end
    endfunction

    // add positions reachable by skipping starred tokens
    function automatic logic [MAX_TOKENS:0] star_closure(logic [MAX_TOKENS:0] s);
        int p;
        for (p = 0; p < pat_len; p++) begin
            if (s[p] && pat_star[p]) begin
                s[p+1] = 1'b1;
            end
        end
        return s;
    endfunction

    function automatic void predict_word(t_req r, logic [7:0] b);
        logic [MAX_TOKENS:0] cur;
        logic [MAX_TOKENS:0] nxt;
        t_verdict v;
        int p;
        case (r)
            REQ_CLEAR: begin
                pat_len = 0;
                pat_ovf = 1'b0;
                reach   = POS_ZERO;
            end
            REQ_APPEND: begin
                if (!pat_ovf) begin
                    if (b == STAR_CHAR && pat_len > 0 && !pat_star[pat_len-1]) begin
                        pat_star[pat_len-1] = 1'b1;
                    end else if (pat_len >= MAX_TOKENS) begin
                        pat_ovf = 1'b1;
                    end else begin
                        pat_byte[pat_len] = b;
                        pat_any[pat_len]  = (b == DOT_CHAR);
                        pat_star[pat_len] = 1'b0;
                        pat_len++;
                    end
                end
                reach = POS_ZERO;
            end
            REQ_TEXT: begin
                cur = star_closure(reach);
                nxt = '0;
                for (p = 0; p < pat_len; p++) begin
                    if (cur[p] && (pat_any[p] || pat_byte[p] == b)) begin
                        if (pat_star[p]) nxt[p] = 1'b1;
                        else nxt[p+1] = 1'b1;
                    end
                end
                reach = nxt;
            end
            default: begin
                cur   = star_closure(reach);
                v.hit = cur[pat_len] && !pat_ovf;
                v.ovf = pat_ovf;
                verdict_q.push_back(v);
                reach = POS_ZERO;
            end
        endcase
    endfunction

    task automatic send_word(t_req r, logic [7:0] b);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_req   <= r;
        in_byte  <= b;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
        predict_word(r, b);
        words_sent++;
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (verdict_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic run_sequence();
        int         kind;
        int         n;
        int         k;
        int         t;
        int         p;
        int         r;
        int         idx;
        logic [7:0] b;
        logic [7:0] txt[$];
        kind = $urandom_range(0, 99);
        if (kind < 15) begin
            n = $urandom_range(1, 6);
            repeat (n) send_word(t_req'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
            return;
        end
        if ($urandom_range(0, 4) != 0) send_word(REQ_CLEAR, 8'($urandom_range(0, 255)));
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(28, 40) : $urandom_range(0, 8);
        for (k = 0; k < n; k++) begin
            r = $urandom_range(0, 99);
            if (r < 40) b = CH_A;
            else if (r < 65) b = CH_B;
            else if (r < 80) b = DOT_CHAR;
            else if (r < 95) b = STAR_CHAR;
            else b = 8'($urandom_range(0, 255));
            send_word(REQ_APPEND, b);
        end
        for (t = $urandom_range(1, 4); t > 0; t--) begin
            txt.delete();
            // mostly texts that walk the pattern, then an occasional corruption
            for (p = 0; p < pat_len; p++) begin
                repeat (pat_star[p] ? $urandom_range(0, 3) : 1) begin
                    txt.push_back(pat_any[p] ? 8'($urandom_range(0, 255)) : pat_byte[p]);
                end
            end
            if ($urandom_range(0, 2) == 0) begin
                b = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                : ($urandom_range(0, 1) ? CH_A : CH_B);
                case ($urandom_range(0, 2))
                    0: txt.push_back(b);
                    1: if (txt.size() > 0) txt.delete($urandom_range(0, txt.size() - 1));
                    default: begin
                        if (txt.size() > 0) begin
                            idx = $urandom_range(0, txt.size() - 1);
                            txt[idx] = b;
                        end
                    end
                endcase
            end
            foreach (txt[i]) send_word(REQ_TEXT, txt[i]);
            send_word(REQ_EOT, 8'($urandom_range(0, 255)));
        end
    endtask

    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            out_stall <= 1'b1;
            hold_left = hold_left - 1;
        end else begin
            out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_verdict want;
        if (rst_n && out_valid && !out_stall) begin
            if (verdict_q.size() == 0) begin
                report_error($sformatf("unexpected result word match=%0b overflow=%0b",
                                       is_match, overflow));
            end else begin
                want = verdict_q.pop_front();
                if (want.hit !== is_match || want.ovf !== overflow) begin
                    report_error($sformatf("match exp %0b got %0b, overflow exp %0b got %0b",
                                           want.hit, is_match, want.ovf, overflow));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        t_dir_row rows [N_DIRECTED];
        int       i;
        int       ph;
        int       idle_tab  [4];
        int       stall_tab [4];
        rows = '{
            '{REQ_EOT,    8'h00,     1'b1, 1'b1, 1'b0},
            '{REQ_TEXT,   8'h00,     1'b0, 1'b0, 1'b0},
            '{REQ_EOT,    8'hFF,     1'b1, 1'b0, 1'b0},
            '{REQ_APPEND, STAR_CHAR, 1'b0, 1'b0, 1'b0},
            '{REQ_APPEND, STAR_CHAR, 1'b0, 1'b0, 1'b0},
            '{REQ_APPEND, STAR_CHAR, 1'b0, 1'b0, 1'b0},
            '{REQ_APPEND, DOT_CHAR,  1'b0, 1'b0, 1'b0},
            '{REQ_APPEND, 8'hFF,     1'b0, 1'b0, 1'b0},
            '{REQ_TEXT,   STAR_CHAR, 1'b0, 1'b0, 1'b0},
            '{REQ_APPEND, 8'h00,     1'b0, 1'b0, 1'b0},
            '{REQ_TEXT,   STAR_CHAR, 1'b0, 1'b0, 1'b0},
            '{REQ_TEXT,   STAR_CHAR, 1'b0, 1'b0, 1'b0},
            '{REQ_TEXT,   8'h41,     1'b0, 1'b0, 1'b0},
            '{REQ_TEXT,   8'hFF,     1'b0, 1'b0, 1'b0},
            '{REQ_TEXT,   8'h00,     1'b0, 1'b0, 1'b0},
            '{REQ_EOT,    8'h00,     1'b0, 1'b0, 1'b0},
            '{REQ_EOT,    8'h55,     1'b0, 1'b0, 1'b0},
            '{REQ_CLEAR,  8'hFF,     1'b0, 1'b0, 1'b0},
            '{REQ_EOT,    8'hAA,     1'b1, 1'b1, 1'b0},
            '{REQ_APPEND, CH_A,      1'b0, 1'b0, 1'b0},
            '{REQ_APPEND, STAR_CHAR, 1'b0, 1'b0, 1'b0},
            '{REQ_EOT,    8'h00,     1'b0, 1'b0, 1'b0},
            '{REQ_TEXT,   CH_A,      1'b0, 1'b0, 1'b0},
            '{REQ_TEXT,   CH_A,      1'b0, 1'b0, 1'b0},
            '{REQ_EOT,    8'h00,     1'b0, 1'b0, 1'b0}
        };
        idle_tab  = '{0, 67, 0, 20};
        stall_tab = '{0, 0, 67, 20};

        repeat (10) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        for (i = 0; i < N_DIRECTED; i++) begin
            send_word(rows[i].req, rows[i].bval);
            if (rows[i].fixed) begin
                verdict_q[verdict_q.size()-1] = '{rows[i].hit, rows[i].ovf};
            end
        end
        drain_results();

        // long receiver hold-off while words keep coming, so the input backs up
        hold_left = HOLD_CYCLES;
        repeat (40) send_word($urandom_range(0, 1) ? REQ_EOT : REQ_TEXT, CH_A);
        drain_results();

        words_sent = 0;
        for (ph = 0; ph < 4; ph++) begin
            send_idle_pct = idle_tab[ph];
            stall_pct     = stall_tab[ph];
            while (words_sent < (ph + 1) * N_RANDOM / 4) run_sequence();
            drain_results();
        end
        stall_pct = 0;

        repeat (8) @(posedge i_clk);
        if (verdict_q.size() != 0) begin
            report_error($sformatf("%0d results never arrived", verdict_q.size()));
        end
        if (err_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
